/* hdl/fbc16_pkg.sv */
// Package for the CRC-16 frame builder: byte type, frame constants and the
// bytewise CRC-16 update. No dependencies.
package fbc16_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] crc_t;

    localparam byte_t MAGIC_FIRST  = 8'hA5;
    localparam byte_t MAGIC_SECOND = 8'h5A;
    localparam crc_t  CRC_POLY     = 16'h1021;
    localparam crc_t  CRC_INIT     = 16'hFFFF;
    localparam crc_t  CRC_MSB      = 16'h8000;

    localparam int MAX_PAYLOAD_BYTES_DEF = 1024;
    // Header (6) + one data word + CRC (2).
    localparam int MAX_RESULTS = 9;

    // One byte of CRC-16, polynomial 0x1021, MSB first.
    function automatic crc_t crc_byte(input crc_t crc_in, input byte_t b);
        crc_t c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* hdl/fbc16_in_if.sv */
// Input channel of the frame builder: valid/ready plus one payload word.
// Depends on fbc16_pkg.
interface fbc16_in_if import fbc16_pkg::*; ;
    logic        valid;
    logic        ready;
    byte_t       frame_type;
    logic [15:0] payload_length;
    byte_t       data_byte;

    modport source (output valid, frame_type, payload_length, data_byte, input ready);
    modport sink   (input valid, frame_type, payload_length, data_byte, output ready);
endinterface

/* hdl/fbc16_out_if.sv */
// Output channel of the frame builder: valid/ready plus one encoded word.
// Depends on fbc16_pkg.
interface fbc16_out_if import fbc16_pkg::*; ;
    logic  valid;
    logic  ready;
    byte_t out_byte;
    logic  frame_end;
    logic  run_last;

    modport source (output valid, out_byte, frame_end, run_last, input ready);
    modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

/* hdl/frame_builder_crc16.sv */
// Serial link frame builder with CRC-16/CCITT-FALSE, top level.
// Depends on fbc16_pkg, fbc16_in_if and fbc16_out_if.
//
// Each input word carries one payload byte. A word that arrives while no frame
// is open starts one: magic A5 5A, type, sequence number, length low and high,
// then the data byte; the CRC (low, then high byte) follows the last payload
// byte. A word is taken into an input register, expanded into up to nine
// output words held in a shift register, and these leave at one word per
// cycle while coded.ready is high. So the output shift register paces input:
// a payload word in mid-frame yields one output word, a frame-opening word
// seven (eight for a zero-length frame, nine for a one-byte frame), and the
// closing word three. The next input word is expanded in the same cycle that
// the last pending output word is taken. An opening word whose length exceeds
// MAX_PAYLOAD_BYTES is dropped without output and the sequence holds.
module frame_builder_crc16
    import fbc16_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fbc16_in_if.sink    item,
    fbc16_out_if.source coded
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1);
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Input register.
    logic        in_vld_reg;
    byte_t       type_reg;
    logic [15:0] len_reg;
    byte_t       data_reg;

    // Frame state.
    byte_t            seq_reg,   seq_next;
    crc_t             crc_reg,   crc_next;
    logic [LEN_W-1:0] rem_reg,   rem_next;
    logic             frm_reg,   frm_next;

    // Output shift register; word 0 is on the port.
    byte_t            buf_reg [MAX_RESULTS];
    byte_t            buf_next [MAX_RESULTS];
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic             crcf_reg,  crcf_next;

    crc_t  c_hdr0, c_hdr1, c_hdr2, c_hdr3, c_data;
    logic  take;
    logic  load;

    assign take = coded.valid && coded.ready;
    assign load = in_vld_reg && ((cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && coded.ready));
    assign item.ready = !in_vld_reg || load;

    assign coded.valid     = (cnt_reg != '0);
    assign coded.out_byte  = buf_reg[0];
    assign coded.run_last  = (cnt_reg == CNT_W'(1));
    assign coded.frame_end = crcf_reg && (cnt_reg == CNT_W'(1));

    // Header CRC chain runs from the init value; in mid-frame the data byte
    // updates the running CRC instead.
    assign c_hdr0 = crc_byte(CRC_INIT, type_reg);
    assign c_hdr1 = crc_byte(c_hdr0, seq_reg);
    assign c_hdr2 = crc_byte(c_hdr1, len_reg[7:0]);
    assign c_hdr3 = crc_byte(c_hdr2, len_reg[15:8]);
    assign c_data = crc_byte(frm_reg ? crc_reg : c_hdr3, data_reg);

    always_comb
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
            buf_next[i] = 8'h00;
        cnt_next  = '0;
        crcf_next = 1'b0;
        seq_next  = seq_reg;
        crc_next  = crc_reg;
        rem_next  = rem_reg;
        frm_next  = frm_reg;
        if (!frm_reg)
        begin
            if (len_reg <= 16'(MAX_PAYLOAD_BYTES))
            begin
                buf_next[0] = MAGIC_FIRST;
                buf_next[1] = MAGIC_SECOND;
                buf_next[2] = type_reg;
                buf_next[3] = seq_reg;
                buf_next[4] = len_reg[7:0];
                buf_next[5] = len_reg[15:8];
                seq_next    = seq_reg + 8'd1;
                if (len_reg == 16'd0)
                begin
                    buf_next[6] = c_hdr3[7:0];
                    buf_next[7] = c_hdr3[15:8];
                    cnt_next    = CNT_W'(8);
                    crcf_next   = 1'b1;
                    crc_next    = CRC_INIT;
                    rem_next    = '0;
                end
                else if (len_reg == 16'd1)
                begin
                    buf_next[6] = data_reg;
                    buf_next[7] = c_data[7:0];
                    buf_next[8] = c_data[15:8];
                    cnt_next    = CNT_W'(9);
                    crcf_next   = 1'b1;
                    crc_next    = CRC_INIT;
                    rem_next    = '0;
                end
                else
                begin
                    buf_next[6] = data_reg;
                    cnt_next    = CNT_W'(7);
                    crc_next    = c_data;
                    rem_next    = LEN_W'(len_reg - 16'd1);
                    frm_next    = 1'b1;
                end
            end
        end
        else
        begin
            buf_next[0] = data_reg;
            if (rem_reg == LEN_W'(1))
            begin
                buf_next[1] = c_data[7:0];
                buf_next[2] = c_data[15:8];
                cnt_next    = CNT_W'(3);
                crcf_next   = 1'b1;
                crc_next    = CRC_INIT;
                rem_next    = '0;
                frm_next    = 1'b0;
            end
            else
            begin
                cnt_next = CNT_W'(1);
                crc_next = c_data;
                rem_next = rem_reg - LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            cnt_reg    <= '0;
            crcf_reg   <= 1'b0;
            seq_reg    <= 8'h00;
            crc_reg    <= CRC_INIT;
            rem_reg    <= '0;
            frm_reg    <= 1'b0;
        end
        else
        begin
            if (item.ready)
                in_vld_reg <= item.valid;
            if (load)
            begin
                cnt_reg  <= cnt_next;
                crcf_reg <= crcf_next;
                seq_reg  <= seq_next;
                crc_reg  <= crc_next;
                rem_reg  <= rem_next;
                frm_reg  <= frm_next;
            end
            else if (take)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            type_reg <= item.frame_type;
            len_reg  <= item.payload_length;
            data_reg <= item.data_byte;
        end
        if (load)
            buf_reg <= buf_next;
        else if (take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
                buf_reg[i] <= buf_reg[i+1];
            buf_reg[MAX_RESULTS-1] <= 8'h00;
        end
    end

endmodule
